>>> design/fdi_pkg.sv
// Shared types and constants for the fractional differintegrator.
package fdi_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int SAMPLE_W   = 32;
  localparam int WEIGHT_W   = 32;
  localparam int ORDER_W    = 14;
  localparam int DECAY_W    = 16;
  localparam int SCALE_W    = 32;
  localparam int RESULT_W   = 48;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [WEIGHT_W-1:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic signed [WEIGHT_W-1:0] W_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [WEIGHT_W-1:0] W_MIN   = 32'sh8000_0000;
  localparam logic signed [ORDER_W-1:0]  Q_MAX   = 14'sd4096;
  localparam logic signed [ORDER_W-1:0]  Q_MIN   = -14'sd4096;

  localparam logic signed [ORDER_W-1:0]  ORDER_RST = 14'sd2048;
  localparam logic [DECAY_W-1:0]         DECAY_RST = 16'd0;
  localparam logic [SCALE_W-1:0]         SCALE_RST = 32'd65536;

  localparam logic [CFG_ADDR_W-1:0] CFG_ORDER_Q      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DECAY_FACTOR = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_SCALE = 2'd2;

  typedef struct packed {
    logic clr;
    logic push;
    logic rot;
    logic wld;
  } cell_ctrl_t;

  typedef struct packed {
    logic vld;
    logic done;
  } wg_stat_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_BUILD,
    ST_IDLE,
    ST_FOLD,
    ST_SHIFT,
    ST_ROT,
    ST_DRAIN,
    ST_RES
  } top_state_t;

  typedef enum logic [2:0] {
    WG_IDLE,
    WG_EMIT,
    WG_MUL,
    WG_ABS,
    WG_DIV,
    WG_SAT
  } wg_state_t;

endpackage

>>> design/fdi_cell.sv
// One chain cell: a history sample and its weight.
module fdi_cell import fdi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cell_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] hist_dn_in,
  input  logic signed [SAMPLE_W-1:0] hist_up_in,
  input  logic signed [WEIGHT_W-1:0] wt_up_in,
  output logic signed [SAMPLE_W-1:0] hist_out,
  output logic signed [WEIGHT_W-1:0] wt_out
);

  logic signed [SAMPLE_W-1:0] hist_r, hist_nxt;
  logic signed [WEIGHT_W-1:0] wt_r, wt_nxt;

  always_comb begin
    hist_nxt = hist_r;
    wt_nxt   = wt_r;
    priority if (ctrl.clr) begin
      hist_nxt = '0;
    end else if (ctrl.push) begin
      hist_nxt = hist_dn_in;
    end else if (ctrl.rot) begin
      hist_nxt = hist_up_in;
      wt_nxt   = wt_up_in;
    end else if (ctrl.wld) begin
      wt_nxt = wt_up_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wt_r <= wt_nxt;
  end

  assign hist_out = hist_r;
  assign wt_out   = wt_r;

endmodule

>>> design/fdi_wgen.sv
// Weight table generator: multiply, then bit-serial divide per weight.
module fdi_wgen import fdi_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [ORDER_W-1:0]  order_q,
  output wg_stat_t                   stat,
  output logic signed [WEIGHT_W-1:0] w_val
);

  localparam int KW = $clog2(DEPTH);
  localparam int FW = KW + 14;
  localparam int PW = WEIGHT_W + FW;
  localparam int DW = PW - 12;
  localparam int CW = $clog2(DW + 1);
  localparam logic [KW-1:0] K_LAST   = KW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

  wg_state_t state_r, state_nxt;

  logic [KW-1:0]              k_r;
  logic signed [ORDER_W-1:0]  qc_r;
  logic signed [WEIGHT_W-1:0] w_r;
  logic signed [PW-1:0]       p_r;
  logic [DW-1:0]              dvd_r;
  logic [KW-1:0]              rem_r;
  logic                       neg_r;
  logic [CW-1:0]              cnt_r;

  logic signed [ORDER_W-1:0]  q_clamp;
  logic signed [FW-1:0]       factor;
  logic signed [PW-1:0]       p_neg;
  logic [PW-1:0]              p_mag;
  logic [KW-1:0]              div_d;
  logic [KW:0]                rs;
  logic [KW:0]                rs_sub;
  logic                       ge;
  logic [KW-1:0]              rem_step;
  logic                       hi_pos;
  logic                       hi_neg;
  logic [WEIGHT_W-1:0]        w_mag;
  logic signed [WEIGHT_W-1:0] w_sat;

  always_comb begin
    if (order_q > Q_MAX) begin
      q_clamp = Q_MAX;
    end else if (order_q < Q_MIN) begin
      q_clamp = Q_MIN;
    end else begin
      q_clamp = order_q;
    end
  end

  assign factor   = $signed({2'b00, k_r, 12'b0}) - {{(FW-ORDER_W){qc_r[ORDER_W-1]}}, qc_r};
  assign p_neg    = -p_r;
  assign p_mag    = p_r[PW-1] ? p_neg : p_r;
  assign div_d    = k_r + KW'(1);
  assign rs       = {rem_r, dvd_r[DW-1]};
  assign ge       = rs >= {1'b0, div_d};
  assign rs_sub   = rs - {1'b0, div_d};
  assign rem_step = ge ? rs_sub[KW-1:0] : rs[KW-1:0];

  assign hi_pos = |dvd_r[DW-1:WEIGHT_W-1];
  assign hi_neg = (|dvd_r[DW-1:WEIGHT_W]) ||
                  (dvd_r[WEIGHT_W-1] && (|dvd_r[WEIGHT_W-2:0]));
  assign w_mag  = dvd_r[WEIGHT_W-1:0];

  always_comb begin
    if (neg_r) begin
      w_sat = hi_neg ? W_MIN : -$signed(w_mag);
    end else begin
      w_sat = hi_pos ? W_MAX : $signed(w_mag);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      WG_IDLE: if (start) state_nxt = WG_EMIT;
      WG_EMIT: state_nxt = (k_r == K_LAST) ? WG_IDLE : WG_MUL;
      WG_MUL:  state_nxt = WG_ABS;
      WG_ABS:  state_nxt = WG_DIV;
      WG_DIV:  if (cnt_r == CNT_LAST) state_nxt = WG_SAT;
      WG_SAT:  state_nxt = WG_EMIT;
      default: state_nxt = WG_IDLE;
    endcase
  end

  always_comb begin
    stat.vld  = (state_r == WG_EMIT);
    stat.done = (state_r == WG_EMIT) && (k_r == K_LAST);
    w_val     = w_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= WG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      WG_IDLE: begin
        if (start) begin
          w_r  <= ONE_Q30;
          k_r  <= '0;
          qc_r <= q_clamp;
        end
      end
      WG_MUL: begin
        p_r <= w_r * factor;
      end
      WG_ABS: begin
        dvd_r <= p_mag[PW-1:12];
        neg_r <= p_r[PW-1];
        rem_r <= '0;
        cnt_r <= '0;
      end
      WG_DIV: begin
        dvd_r <= {dvd_r[DW-2:0], ge};
        rem_r <= rem_step;
        cnt_r <= cnt_r + CW'(1);
      end
      WG_SAT: begin
        w_r <= w_sat;
        k_r <= k_r + KW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/fdi_mac.sv
// Shared multiply-accumulate over the chain, then output scaling and saturation.
module fdi_mac import fdi_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       term_vld,
  input  logic                       term_last,
  input  logic signed [SAMPLE_W-1:0] hist,
  input  logic signed [WEIGHT_W-1:0] wt,
  input  logic [SCALE_W-1:0]         scale,
  output logic                       done,
  output logic signed [RESULT_W-1:0] result
);

  localparam int KW    = $clog2(DEPTH);
  localparam int PRD_W = SAMPLE_W + WEIGHT_W;
  localparam int ACC_W = 50 + KW;
  localparam int HI_W  = ACC_W - 32;
  localparam int RES_W = HI_W + 33;
  localparam logic signed [RESULT_W-1:0] MAX48 = {1'b0, {(RESULT_W-1){1'b1}}};
  localparam logic signed [RESULT_W-1:0] MIN48 = {1'b1, {(RESULT_W-1){1'b0}}};
  localparam logic signed [PRD_W-1:0] RND14 = PRD_W'(16383);

  logic signed [PRD_W-1:0]    prod_r;
  logic                       pv_r;
  logic                       pl_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       s1_r;
  logic                       neg_r;
  logic [HI_W-1:0]            hi_r;
  logic [63:0]                plo_r;
  logic                       s2_r;
  logic [HI_W+31:0]           phi_r;
  logic [31:0]                plo_top_r;
  logic                       s3_r;
  logic                       done_r;
  logic signed [RESULT_W-1:0] result_r;

  logic signed [PRD_W-1:0]    tsum;
  logic signed [PRD_W-1:0]    tsh;
  logic signed [ACC_W-1:0]    term;
  logic signed [ACC_W-1:0]    acc_neg;
  logic [ACC_W-1:0]           mag;
  logic [RES_W-1:0]           res;
  logic                       ovf;
  logic signed [RESULT_W-1:0] res48;
  logic signed [RESULT_W-1:0] result_nxt;

  assign tsum    = prod_r + (prod_r[PRD_W-1] ? RND14 : '0);
  assign tsh     = tsum >>> 14;
  assign term    = $signed(tsh[ACC_W-1:0]);
  assign acc_neg = -acc_r;
  assign mag     = acc_r[ACC_W-1] ? acc_neg : acc_r;
  assign res     = {1'b0, phi_r} + {{(HI_W+1){1'b0}}, plo_top_r};
  assign ovf     = |res[RES_W-1:RESULT_W-1];
  assign res48   = $signed(res[RESULT_W-1:0]);

  always_comb begin
    if (ovf) begin
      result_nxt = neg_r ? MIN48 : MAX48;
    end else begin
      result_nxt = neg_r ? -res48 : res48;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= 1'b0;
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      s3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pv_r   <= term_vld;
      s1_r   <= pv_r && pl_r;
      s2_r   <= s1_r;
      s3_r   <= s2_r;
      done_r <= s3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (term_vld) begin
      prod_r <= hist * wt;
      pl_r   <= term_last;
    end
    if (start) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + term;
    end
    if (s1_r) begin
      neg_r <= acc_r[ACC_W-1];
      hi_r  <= mag[ACC_W-1:32];
      plo_r <= mag[31:0] * scale;
    end
    if (s2_r) begin
      phi_r     <= hi_r * scale;
      plo_top_r <= plo_r[63:32];
    end
    if (s3_r) begin
      result_r <= result_nxt;
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

>>> design/fractional_differintegrator_top.sv
// Top level of the fractional differintegrator: cell chain, control and channels.
//
//  channel | direction | signals                                   | contents
//  in      | slave     | in_tvalid in_tready in_tdata in_tuser     | sample / command
//  out     | master    | out_tvalid out_tready out_tdata           | result_value
//  cfg     | write     | cfg_we cfg_addr cfg_wdata                 | order_q, decay, scale
//
// Push: the chain makes one rotation past a shared MAC; a new item is accepted only after the last result is loaded.
// Clear: zeroes the history and rebuilds the weight table through the bit-serial weight divider.
// Reset: history zeroes at once; the weight build then runs before in_tready rises.
// A stalled output holds one result; the next push may run behind it and waits at the end.
module fractional_differintegrator_top import fdi_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [31:0] sample
  input  logic                  in_tuser,   // [0] command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [RESULT_W-1:0]   out_tdata,  // [47:0] result_value
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int KW = $clog2(DEPTH);
  localparam logic [KW-1:0] RC_LAST = KW'(DEPTH - 1);

  top_state_t state_r, state_nxt;

  logic signed [ORDER_W-1:0]  order_q_r;
  logic [DECAY_W-1:0]         decay_r;
  logic [SCALE_W-1:0]         scale_r;
  logic                       clr_pend_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [48:0]         fprod_r;
  logic [KW-1:0]              rc_r;
  logic                       out_valid_r;
  logic [RESULT_W-1:0]        out_data_r;

  logic                       accept;
  logic                       out_load;
  logic                       wg_start;
  logic                       mac_start;
  logic                       term_vld;
  logic                       term_last;
  cell_ctrl_t                 ctrl;
  wg_stat_t                   wg_stat;
  logic signed [WEIGHT_W-1:0] w_val;
  logic                       mac_done;
  logic signed [RESULT_W-1:0] mac_result;

  logic signed [48:0]         fq_sum;
  logic signed [48:0]         fq_sh;
  logic signed [32:0]         fq;
  logic signed [33:0]         fold_sum;
  logic signed [SAMPLE_W-1:0] fold_val;

  logic signed [SAMPLE_W-1:0] hist_q  [DEPTH];
  logic signed [WEIGHT_W-1:0] wt_q    [DEPTH];
  logic signed [SAMPLE_W-1:0] hist_dn [DEPTH];
  logic signed [SAMPLE_W-1:0] hist_up [DEPTH];
  logic signed [WEIGHT_W-1:0] wt_up   [DEPTH];

  assign accept = in_tvalid && in_tready;

  // fold the expiring sample into its neighbor
  assign fq_sum   = fprod_r + (fprod_r[48] ? 49'sd65535 : 49'sd0);
  assign fq_sh    = fq_sum >>> 16;
  assign fq       = fq_sh[32:0];
  assign fold_sum = {{2{hist_q[1][SAMPLE_W-1]}}, hist_q[1]} + {fq[32], fq};

  always_comb begin
    if (fold_sum[33:31] == 3'b000 || fold_sum[33:31] == 3'b111) begin
      fold_val = fold_sum[SAMPLE_W-1:0];
    end else begin
      fold_val = fold_sum[33] ? W_MIN : W_MAX;
    end
  end

  genvar j;
  generate
    for (j = 0; j < DEPTH; j++) begin : g_chain
      if (j == DEPTH - 1) begin : g_top
        assign hist_dn[j] = sample_r;
      end else if (j == 0) begin : g_bot
        assign hist_dn[j] = fold_val;
      end else begin : g_mid
        assign hist_dn[j] = hist_q[j+1];
      end

      if (j == 0) begin : g_wrap
        assign hist_up[j] = hist_q[DEPTH-1];
        assign wt_up[j]   = (state_r == ST_BUILD) ? w_val : wt_q[DEPTH-1];
      end else begin : g_link
        assign hist_up[j] = hist_q[j-1];
        assign wt_up[j]   = wt_q[j-1];
      end

      fdi_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .hist_dn_in (hist_dn[j]),
        .hist_up_in (hist_up[j]),
        .wt_up_in   (wt_up[j]),
        .hist_out   (hist_q[j]),
        .wt_out     (wt_q[j])
      );
    end
  endgenerate

  fdi_wgen #(
    .DEPTH (DEPTH)
  ) u_wgen (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (wg_start),
    .order_q (order_q_r),
    .stat    (wg_stat),
    .w_val   (w_val)
  );

  fdi_mac #(
    .DEPTH (DEPTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mac_start),
    .term_vld  (term_vld),
    .term_last (term_last),
    .hist      (hist_q[DEPTH-1]),
    .wt        (wt_q[DEPTH-1]),
    .scale     (scale_r),
    .done      (mac_done),
    .result    (mac_result)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:  state_nxt = ST_BUILD;
      ST_BUILD: if (wg_stat.done) state_nxt = clr_pend_r ? ST_RES : ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = in_tuser ? ST_INIT : ST_FOLD;
      ST_FOLD:  state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = ST_ROT;
      ST_ROT:   if (rc_r == RC_LAST) state_nxt = ST_DRAIN;
      ST_DRAIN: if (mac_done) state_nxt = ST_RES;
      ST_RES:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    ctrl.clr  = accept && in_tuser;
    ctrl.push = (state_r == ST_SHIFT);
    ctrl.rot  = (state_r == ST_ROT);
    ctrl.wld  = (state_r == ST_BUILD) && wg_stat.vld;
    wg_start  = (state_r == ST_INIT);
    mac_start = (state_r == ST_SHIFT);
    term_vld  = (state_r == ST_ROT);
    term_last = (rc_r == RC_LAST);
    out_load  = (state_r == ST_RES) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      order_q_r   <= ORDER_RST;
      decay_r     <= DECAY_RST;
      scale_r     <= SCALE_RST;
    end else begin
      state_r <= state_nxt;
      if (accept && in_tuser) begin
        clr_pend_r <= 1'b1;
      end else if (out_load) begin
        clr_pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_ORDER_Q:      order_q_r <= cfg_wdata[ORDER_W-1:0];
          CFG_DECAY_FACTOR: decay_r   <= cfg_wdata[DECAY_W-1:0];
          CFG_OUTPUT_SCALE: scale_r   <= cfg_wdata[SCALE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_tdata;
    end
    if (state_r == ST_FOLD) begin
      fprod_r <= hist_q[0] * $signed({1'b0, decay_r});
    end
    if (state_r == ST_SHIFT) begin
      rc_r <= '0;
    end else if (state_r == ST_ROT) begin
      rc_r <= rc_r + KW'(1);
    end
    if (out_load) begin
      out_data_r <= clr_pend_r ? '0 : mac_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_mac_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_DRAIN)
    else $error("sum finished outside the drain state");

  a_wload_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    wg_stat.vld |-> state_r == ST_BUILD)
    else $error("weight emitted outside the build state");

  a_clear_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && clr_pend_r) |=> (out_tvalid && out_tdata == '0))
    else $error("clear transaction returned a nonzero result");
`endif

endmodule

>>> tb/fractional_differintegrator_top_test.sv
// Self-checking testbench for the fractional differintegrator top level.
module fractional_differintegrator_top_test;
  import fdi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

  localparam int     N_PHASES        = 8;
  localparam int     ITEMS_PER_PHASE = 242;
  localparam int     DRAIN_CYCLES    = 4 * (DEPTH_DEF + 8);
  localparam longint CYCLE_LIMIT     = 5_000_000;

  localparam bit [63:0]           SUM_MAX  = (64'd1 << 47) - 64'd1;
  localparam logic [RESULT_W-1:0] RES_POS  = 48'h7FFF_FFFF_FFFF;
  localparam logic [RESULT_W-1:0] RES_NEG  = 48'h8000_0000_0000;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] data;
    logic                lit;
    logic [RESULT_W-1:0] lit_val;
  } dir_step_t;

  typedef struct packed {
    logic [ORDER_W-1:0] q;
    logic [DECAY_W-1:0] decay;
    logic [SCALE_W-1:0] scale;
    logic               clr_first;
    logic               rnd;
  } phase_cfg_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata;   // [31:0] sample
  logic                  in_tuser;   // [0] command
  logic                  out_tvalid;
  logic                  out_tready;
  logic [RESULT_W-1:0]   out_tdata;  // [47:0] result_value
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic signed [SAMPLE_W-1:0] gl_hist   [DEPTH_DEF];
  logic signed [WEIGHT_W-1:0] gl_weight [DEPTH_DEF];
  int                         gl_ptr;
  logic [ORDER_W-1:0]         order_reg;
  logic [DECAY_W-1:0]         decay_reg;
  logic [SCALE_W-1:0]         scale_reg;

  logic [RESULT_W-1:0] want_results [$];
  int                  errors = 0;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  stall_left;
  longint              cycle_count = 0;

  dir_step_t dir_steps [16] = '{
    '{CMD_CLEAR, 32'hFFFF_FFFF, 1'b1, 48'h0},
    '{CMD_PUSH,  32'h7FFF_FFFF, 1'b1, 48'h0000_7FFF_FFFF},
    '{CMD_PUSH,  32'h0000_0000, 1'b0, 48'h0},
    '{CMD_PUSH,  32'h8000_0000, 1'b0, 48'h0},
    '{CMD_CLEAR, 32'h0000_0000, 1'b1, 48'h0},
    '{CMD_PUSH,  32'h8000_0000, 1'b1, 48'hFFFF_8000_0000},
    '{CMD_PUSH,  32'hFFFF_FFFF, 1'b0, 48'h0},
    '{CMD_PUSH,  32'h0000_0001, 1'b0, 48'h0},
    '{CMD_PUSH,  32'h7FFF_FFFF, 1'b0, 48'h0},
    '{CMD_PUSH,  32'h5555_5555, 1'b0, 48'h0},
    '{CMD_PUSH,  32'hAAAA_AAAA, 1'b0, 48'h0},
    '{CMD_PUSH,  32'h0001_0000, 1'b0, 48'h0},
    '{CMD_PUSH,  32'hFFFF_0000, 1'b0, 48'h0},
    '{CMD_CLEAR, 32'h1234_5678, 1'b1, 48'h0},
    '{CMD_PUSH,  32'h0001_0000, 1'b1, 48'h0000_0001_0000},
    '{CMD_PUSH,  32'h7FFF_FFFF, 1'b0, 48'h0}
  };

  // order clamps above and below, zero scale, full scale, deferred order change
  phase_cfg_t phases [N_PHASES] = '{
    '{14'h1FFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0},
    '{14'h2000, 16'h0000, 32'h0000_0000, 1'b1, 1'b0},
    '{14'h3000, 16'h8000, 32'h0000_0001, 1'b1, 1'b0},
    '{14'h1000, 16'hFFFF, 32'h0001_0000, 1'b0, 1'b0},
    '{14'h0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b1},
    '{14'h0000, 16'h0000, 32'h0000_0000, 1'b0, 1'b1},
    '{14'h0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b1},
    '{14'h0000, 16'h0000, 32'h0000_0000, 1'b1, 1'b1}
  };

  fractional_differintegrator_top #(
    .DEPTH(DEPTH_DEF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint trunc_shr(longint p, int n);
    longint mag;
    mag = (p < 0) ? -p : p;
    mag = mag >> n;
    return (p < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > longint'(W_MAX)) return W_MAX;
    if (v < longint'(W_MIN)) return W_MIN;
    return v[31:0];
  endfunction

  function void build_gl_weights();
    longint q;
    longint w;
    int     k;
    q = longint'($signed(order_reg));
    if (q > longint'(Q_MAX)) q = longint'(Q_MAX);
    if (q < longint'(Q_MIN)) q = longint'(Q_MIN);
    w = longint'(ONE_Q30);
    gl_weight[DEPTH_DEF-1] = ONE_Q30;
    for (k = 0; k < DEPTH_DEF - 1; k++) begin
      w = (w * (64'sd4096 * longint'(k) - q)) / (64'sd4096 * longint'(k + 1));
      gl_weight[DEPTH_DEF-2-k] = clip32(w);
      w = longint'(gl_weight[DEPTH_DEF-2-k]);
    end
  endfunction

  function void clear_gl_history();
    foreach (gl_hist[i]) gl_hist[i] = '0;
    gl_ptr = 0;
  endfunction

  function logic [RESULT_W-1:0] next_differintegral(logic cmd, logic [SAMPLE_W-1:0] data);
    int        cur;
    int        nxt;
    int        idx;
    int        i;
    longint    fold;
    longint    acc;
    bit [63:0] mag;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] scl;
    bit [63:0] res;
    bit        neg;
    if (cmd == CMD_CLEAR) begin
      clear_gl_history();
      build_gl_weights();
      return '0;
    end
    cur = gl_ptr;
    nxt = (cur + 1) % DEPTH_DEF;
    fold = trunc_shr(longint'(gl_hist[cur]) * longint'(decay_reg), 16);
    gl_hist[nxt] = clip32(longint'(gl_hist[nxt]) + fold);
    gl_hist[cur] = data;
    gl_ptr = nxt;
    acc = 0;
    idx = gl_ptr;
    for (i = 0; i < DEPTH_DEF; i++) begin
      acc += trunc_shr(longint'(gl_hist[idx]) * longint'(gl_weight[i]), 14);
      idx = (idx + 1) % DEPTH_DEF;
    end
    neg = acc < 0;
    mag = neg ? -acc : acc;
    hi = mag >> 32;
    lo = mag & 64'hFFFF_FFFF;
    scl = 64'(scale_reg);
    res = hi * scl + ((lo * scl) >> 32);
    if (res > SUM_MAX) return neg ? RES_NEG : RES_POS;
    res = neg ? -res : res;
    return res[RESULT_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_point();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5: begin
        v = $urandom_range(0, 32'h000F_FFFF);
        if ($urandom_range(1)) v = -v;
      end
      6: begin
        case ($urandom_range(4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h0000_0001;
          default: v = 32'h0000_0000;
        endcase
      end
      default: v = 32'($signed($urandom) >>> $urandom_range(1, 24));
    endcase
    return v;
  endfunction

  task report_mismatch(string what, logic [RESULT_W-1:0] want, logic [RESULT_W-1:0] got);
    $display("MISMATCH %s: expected %h, got %h at cycle %0d", what, want, got, cycle_count);
    errors++;
  endtask

  task write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      CFG_ORDER_Q:      order_reg = data[ORDER_W-1:0];
      CFG_DECAY_FACTOR: decay_reg = data[DECAY_W-1:0];
      CFG_OUTPUT_SCALE: scale_reg = data[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task set_config(phase_cfg_t pc, logic [17:0] q_pad, logic [15:0] d_pad);
    write_reg(CFG_ORDER_Q, {q_pad, pc.q});
    write_reg(CFG_DECAY_FACTOR, {d_pad, pc.decay});
    write_reg(CFG_OUTPUT_SCALE, pc.scale);
    write_reg(CFG_UNUSED, $urandom);
    cfg_we <= 1'b0;
  endtask

  task send_item(logic cmd, logic [SAMPLE_W-1:0] data, logic use_lit,
                 logic [RESULT_W-1:0] lit_val);
    logic [RESULT_W-1:0] want;
    int                  gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    want = next_differintegral(cmd, data);
    if (use_lit) want = lit_val;
    want_results.push_back(want);
  endtask

  task settle();
    in_tvalid <= 1'b0;
    while (want_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(99) < recv_idle_pct) begin
      stall_left <= ($urandom_range(11) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (want_results.size() == 0) begin
        report_mismatch("unexpected result", 'x, out_tdata);
      end else if (out_tdata !== want_results[0]) begin
        report_mismatch("result_value", want_results[0], out_tdata);
        void'(want_results.pop_front());
      end else begin
        void'(want_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fractional_differintegrator_top regression: fail");
      $finish;
    end
  end

  initial begin
    phase_cfg_t pc;
    int         p;
    int         n;
    send_idle_pct = 34;
    recv_idle_pct = 63;
    order_reg     = ORDER_RST;
    decay_reg     = DECAY_RST;
    scale_reg     = SCALE_RST;
    clear_gl_history();
    build_gl_weights();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_PUSH;
    cfg_we     <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!in_tready);

    foreach (dir_steps[i]) begin
      send_item(dir_steps[i].cmd, dir_steps[i].data, dir_steps[i].lit, dir_steps[i].lit_val);
    end
    settle();

    for (p = 0; p < N_PHASES; p++) begin
      send_idle_pct = (p < 3) ? 34 : (p < 6) ? 63 : 0;
      recv_idle_pct = (p < 3) ? 63 : (p < 6) ? 34 : 0;
      pc = phases[p];
      if (pc.rnd) begin
        pc.q     = ($urandom_range(3) == 0) ? 14'($urandom)
                                            : 14'($urandom_range(0, 8192) - 4096);
        pc.decay = $urandom_range(0, 65535);
        case ($urandom_range(3))
          0: pc.scale = $urandom;
          1: pc.scale = $urandom_range(1, 32'h0004_0000);
          2: pc.scale = $urandom_range(32'h0000_8000, 32'h0002_0000);
          default: pc.scale = 32'h0001_0000;
        endcase
        set_config(pc, 18'($urandom), 16'($urandom));
      end else begin
        set_config(pc, '0, '0);
      end
      n = 0;
      if (pc.clr_first) begin
        send_item(CMD_CLEAR, $urandom, 1'b0, '0);
        n++;
      end
      for (; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 3) send_item(CMD_CLEAR, $urandom, 1'b0, '0);
        else send_item(CMD_PUSH, rand_point(), 1'b0, '0);
      end
      settle();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && want_results.size() == 0) begin
      $display("fractional_differintegrator_top regression: pass");
    end else begin
      $display("fractional_differintegrator_top regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
design/fdi_pkg.sv
design/fdi_cell.sv
design/fdi_wgen.sv
design/fdi_mac.sv
design/fractional_differintegrator_top.sv
tb/fractional_differintegrator_top_test.sv
